### hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Types and constants shared by the character LCD command sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

    // request codes on the input item
    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CHAR   = 3'd1,
        OP_ADDR   = 3'd2,
        OP_TOP    = 3'd3,
        OP_BOTTOM = 3'd4,
        OP_TOGGLE = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_SCROLL = 3'd7
    } t_op;

    // shape of the command list held in the work register
    typedef enum logic [2:0] {
        K_INIT,    // nine-command power-up sequence
        K_ADDR,    // one set-address
        K_DATA,    // data write, then set-address
        K_TAB2,    // set-address 0, then set-address of the cursor
        K_CLEAR,   // clear display
        K_SCROLL   // shift display left
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] REG_PULSE_US  = 2'd0;
    localparam logic [1:0] REG_CLEAR_US  = 2'd1;
    localparam logic [1:0] REG_SCROLL_US = 2'd2;

    localparam logic [15:0] CLEAR_US_RST  = 16'd1600;
    localparam logic [19:0] SCROLL_US_RST = 20'd500000;

    // LCD instruction encodings
    localparam logic [7:0] CMD_FUNC_SET = 8'h3C;
    localparam logic [7:0] CMD_DISP_OFF = 8'h08;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_ENTRY    = 8'h04;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_SHIFT    = 8'h18;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;

    localparam logic [6:0] ADDR_MAX = 7'h7F;

    localparam logic [19:0] INIT_CLEAR_WAIT_US = 20'd2000;
    localparam logic [3:0]  INIT_CMDS          = 4'd9;

    function automatic logic [7:0] init_code(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3: c = CMD_FUNC_SET;
            4'd4:    c = CMD_DISP_OFF;
            4'd5:    c = CMD_CLEAR;
            4'd6:    c = CMD_ENTRY;
            4'd7:    c = CMD_SET_ADDR;   // cursor is zero here
            4'd8:    c = CMD_DISP_ON;
            default: c = CMD_DISP_ON;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] init_before(input logic [3:0] idx);
        logic [15:0] w;
        case (idx)
            4'd0:    w = 16'd15000;
            4'd1:    w = 16'd41000;
            4'd2:    w = 16'd100;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

### hdl/char_lcd_command_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_command_sequencer
// Turns display requests into 8-bit character LCD commands and tracks the
// display-RAM cursor.
// ----------------------------------------------------------------------------
// The accepting edge loads the work register; the first command of a request
// then moves to the output register on an edge at which the output can advance.
// Throughput: one command per cycle unless the output stalls; a request of N
// commands (1, 2 or 9) holds the single work register until its last command;
// the next request enters in the cycle that command moves to the output register.
// Reset (synchronous, active low): cursor 0, clear wait 1600 us, scroll wait
// 500000 us, work and output registers empty.
// ----------------------------------------------------------------------------
module char_lcd_command_sequencer #(
    parameter int TAB_STEP     = 4,
    parameter int ROW_TWO_BASE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // op[2:0], char_code[10:3], target_address[17:11]
    // command stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // code_byte[7:0], wait_before_us[23:8],
                                         // wait_after_us[43:24]
    output logic        o_m_axis_tuser,  // reg_select
    output logic        o_m_axis_tlast   // last
);

    localparam logic [7:0] STEP8 = 8'(TAB_STEP);
    localparam logic [6:0] ROW2  = 7'(ROW_TWO_BASE);

    // configuration
    logic [15:0] r_clear_us;
    logic [19:0] r_scroll_us;

    // cursor
    logic [6:0]  r_cursor, n_cursor;

    // work register
    logic                 r_w_valid;
    clcd_pkg::t_kind      r_w_kind, n_kind;
    logic [3:0]           r_w_idx;
    logic [7:0]           r_w_char;
    logic [6:0]           r_w_cur;

    // output register
    logic        r_o_valid;
    logic        r_o_rs;
    logic [7:0]  r_o_code;
    logic [15:0] r_o_before;
    logic [19:0] r_o_after;
    logic        r_o_last;

    clcd_pkg::t_op in_op;
    logic [7:0]    in_char;
    logic [6:0]    in_addr;
    logic [7:0]    tab_sum;
    logic          tab_wrap;
    logic          m_adv;
    logic          s_fire;
    logic          w_last;
    logic [3:0]    w_count;

    logic        g_rs;
    logic [7:0]  g_code;
    logic [15:0] g_before;
    logic [19:0] g_after;

    assign in_op   = clcd_pkg::t_op'(i_s_axis_tdata[2:0]);
    assign in_char = i_s_axis_tdata[10:3];
    assign in_addr = i_s_axis_tdata[17:11];

    assign tab_sum  = {1'b0, r_cursor} + STEP8;
    assign tab_wrap = tab_sum > {1'b0, clcd_pkg::ADDR_MAX};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_us  <= clcd_pkg::CLEAR_US_RST;
            r_scroll_us <= clcd_pkg::SCROLL_US_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                clcd_pkg::REG_PULSE_US:  ; // enable timing lives in the pin driver
                clcd_pkg::REG_CLEAR_US:  r_clear_us  <= i_cfg_data[15:0];
                clcd_pkg::REG_SCROLL_US: r_scroll_us <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request decode: next cursor and command list shape
    always_comb begin
        n_cursor = r_cursor;
        n_kind   = clcd_pkg::K_ADDR;
        case (in_op)
            clcd_pkg::OP_INIT: begin
                n_cursor = '0;
                n_kind   = clcd_pkg::K_INIT;
            end
            clcd_pkg::OP_CHAR: begin
                if (in_char == clcd_pkg::CHAR_NEWLINE) begin
                    n_cursor = (r_cursor < ROW2) ? ROW2 : '0;
                end else if (in_char == clcd_pkg::CHAR_TAB) begin
                    n_cursor = tab_wrap ? STEP8[6:0] : tab_sum[6:0];
                    n_kind   = tab_wrap ? clcd_pkg::K_TAB2 : clcd_pkg::K_ADDR;
                end else begin
                    n_cursor = r_cursor + 7'd1;
                    n_kind   = clcd_pkg::K_DATA;
                end
            end
            clcd_pkg::OP_ADDR:   n_cursor = in_addr;
            clcd_pkg::OP_TOP:    n_cursor = '0;
            clcd_pkg::OP_BOTTOM: n_cursor = ROW2;
            clcd_pkg::OP_TOGGLE: n_cursor = (r_cursor < ROW2) ? ROW2 : '0;
            clcd_pkg::OP_CLEAR: begin
                n_cursor = '0;
                n_kind   = clcd_pkg::K_CLEAR;
            end
            clcd_pkg::OP_SCROLL: n_kind = clcd_pkg::K_SCROLL;
            default: ;
        endcase
    end

    always_comb begin
        case (r_w_kind)
            clcd_pkg::K_INIT: w_count = clcd_pkg::INIT_CMDS;
            clcd_pkg::K_DATA,
            clcd_pkg::K_TAB2: w_count = 4'd2;
            default:          w_count = 4'd1;
        endcase
    end

    assign w_last          = r_w_idx == (w_count - 4'd1);
    assign m_adv           = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_w_valid || (m_adv && w_last);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // command generation for the current work index
    always_comb begin
        g_rs     = 1'b0;
        g_code   = clcd_pkg::CMD_SET_ADDR | {1'b0, r_w_cur};
        g_before = '0;
        g_after  = '0;
        case (r_w_kind)
            clcd_pkg::K_INIT: begin
                g_code   = clcd_pkg::init_code(r_w_idx);
                g_before = clcd_pkg::init_before(r_w_idx);
                if (g_code == clcd_pkg::CMD_CLEAR) begin
                    g_after = clcd_pkg::INIT_CLEAR_WAIT_US;
                end
            end
            clcd_pkg::K_DATA: begin
                if (r_w_idx == 4'd0) begin
                    g_rs   = 1'b1;
                    g_code = r_w_char;
                end
            end
            clcd_pkg::K_TAB2: begin
                if (r_w_idx == 4'd0) begin
                    g_code = clcd_pkg::CMD_SET_ADDR;
                end
            end
            clcd_pkg::K_CLEAR: begin
                g_code  = clcd_pkg::CMD_CLEAR;
                g_after = {4'd0, r_clear_us};
            end
            clcd_pkg::K_SCROLL: begin
                g_code  = clcd_pkg::CMD_SHIFT;
                g_after = r_scroll_us;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_w_valid <= 1'b0;
            r_w_idx   <= '0;
            r_w_kind  <= clcd_pkg::K_ADDR;
        end else if (s_fire) begin
            r_cursor  <= n_cursor;
            r_w_valid <= 1'b1;
            r_w_idx   <= '0;
            r_w_kind  <= n_kind;
        end else if (m_adv && r_w_valid) begin
            if (w_last) begin
                r_w_valid <= 1'b0;
            end else begin
                r_w_idx <= r_w_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_w_char <= in_char;
            r_w_cur  <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (m_adv) begin
            r_o_valid <= r_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_adv && r_w_valid) begin
            r_o_rs     <= g_rs;
            r_o_code   <= g_code;
            r_o_before <= g_before;
            r_o_after  <= g_after;
            r_o_last   <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {4'd0, r_o_after, r_o_before, r_o_code};
    assign o_m_axis_tuser  = r_o_rs;
    assign o_m_axis_tlast  = r_o_last;

    // work index never runs past the list length
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_valid |-> (r_w_idx < w_count))
        else $error("work index past end of command list");

    // an accepted request always lands in the work register
    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_w_valid && r_w_idx == 4'd0))
        else $error("accepted request not loaded");

    // a clear request homes the cursor
    a_clear_homes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_op == clcd_pkg::OP_CLEAR) |=> (r_cursor == 7'd0))
        else $error("cursor not homed by clear");

    // last command leaving with no new request empties the work register
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_adv && r_w_valid && w_last && !s_fire) |=> !r_w_valid)
        else $error("work register not freed after last command");

    // output register only carries tlast for the final command of a request
    a_last_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_adv && r_w_valid) |=> (r_o_last == $past(w_last)))
        else $error("tlast does not match end of command list");

endmodule
